[rtl/spot_pkg.sv]
// spot_pkg: shared types for the shape pair overlap test
// no dependencies
`default_nettype none

package spot_pkg;

   // which pair of shapes a word carries
   typedef enum logic [1:0] {
      MODE_RECT_RECT,
      MODE_CIRC_CIRC,
      MODE_CIRC_RECT
   } mode_type;

endpackage

`default_nettype wire

[rtl/spot_square.sv]
// spot_square: registered unsigned squaring unit, one operand per cycle while enable is high
// standalone, used by shape_pair_overlap_test
`default_nettype none

module spot_square #(
   parameter int WIDTH = 17
) (
   input  wire  logic               clock,
   input  wire  logic               enable,
   input  wire  logic [WIDTH-1:0]   operand,
   output logic       [2*WIDTH-1:0] square
);

   logic [2*WIDTH-1:0] square_ff;
   logic [2*WIDTH-1:0] square_in;

   assign square_in = {{WIDTH{1'b0}}, operand} * {{WIDTH{1'b0}}, operand};

   always_ff @(posedge clock) begin
      if (enable) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

`default_nettype wire

[rtl/shape_pair_overlap_test.sv]
// shape_pair_overlap_test: overlap flag for a pair of rectangles or circles
// depends on spot_pkg and spot_square
//
// usage
//   req_ channel: one word per pair of shapes, kind 0 rectangle (center,
//   width, height) or kind 1 circle (center, radius in extent_x), signed
//   fixed point centers. rsp_ channel: one word per request, rsp_hit.
//   both channels use valid/ready, a word moves when both are high.
// timing
//   four register stages: abs differences, bound compares, squares,
//   sum and compare. one word per cycle sustained while rsp_ready stays
//   high; the squaring multipliers and the final add/compare set the
//   stage depth.
// reset
//   synchronous, active high: all stage valid bits clear, the pipeline
//   comes out empty and req_ready is high.
// stall
//   when the receiver holds rsp_ready low, stages behind the output keep
//   filling bubbles; req_ready drops only when every stage holds a word.
//   nothing is dropped or repeated.
`default_nettype none

module shape_pair_overlap_test
   import spot_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire  logic                         clock,
   input  wire  logic                         reset,
   input  wire  logic                         req_valid,
   output logic                               req_ready,
   input  wire  logic                         req_kind_a,
   input  wire  logic signed [COORD_BITS-1:0] req_a_center_x,
   input  wire  logic signed [COORD_BITS-1:0] req_a_center_y,
   input  wire  logic        [COORD_BITS-2:0] req_a_extent_x,
   input  wire  logic        [COORD_BITS-2:0] req_a_extent_y,
   input  wire  logic                         req_kind_b,
   input  wire  logic signed [COORD_BITS-1:0] req_b_center_x,
   input  wire  logic signed [COORD_BITS-1:0] req_b_center_y,
   input  wire  logic        [COORD_BITS-2:0] req_b_extent_x,
   input  wire  logic        [COORD_BITS-2:0] req_b_extent_y,
   output logic                               rsp_valid,
   input  wire  logic                         rsp_ready,
   output logic                               rsp_hit
);

   localparam int C = COORD_BITS;
   localparam int W = COORD_BITS + 1;   // doubled distances and bounds
   localparam int Q = 2 * W;            // squares

   // stage handshake
   logic adv1, adv2, adv3, adv4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // ---------------- stage 1: center distances, operand selection
   logic [C:0]   diff_x, diff_y;
   logic [C-1:0] mag_x, mag_y;
   logic [C-1:0] sum_x, sum_y;

   mode_type     s1_mode_in, s1_mode_ff;
   logic [C-1:0] s1_dx_in, s1_dx_ff, s1_dy_in, s1_dy_ff;
   logic [C-1:0] s1_px_in, s1_px_ff, s1_py_in, s1_py_ff;
   logic [C-2:0] s1_r_in, s1_r_ff;

   assign diff_x = {req_a_center_x[C-1], req_a_center_x}
                 - {req_b_center_x[C-1], req_b_center_x};
   assign diff_y = {req_a_center_y[C-1], req_a_center_y}
                 - {req_b_center_y[C-1], req_b_center_y};
   // magnitude always fits in C bits
   assign mag_x  = diff_x[C] ? (~diff_x[C-1:0] + C'(1)) : diff_x[C-1:0];
   assign mag_y  = diff_y[C] ? (~diff_y[C-1:0] + C'(1)) : diff_y[C-1:0];
   assign sum_x  = {1'b0, req_a_extent_x} + {1'b0, req_b_extent_x};
   assign sum_y  = {1'b0, req_a_extent_y} + {1'b0, req_b_extent_y};

   always_comb begin
      s1_dx_in = mag_x;
      s1_dy_in = mag_y;
      s1_px_in = sum_x;
      s1_py_in = sum_y;
      s1_r_in  = req_a_extent_x;
      if (!req_kind_a && !req_kind_b) begin
         s1_mode_in = MODE_RECT_RECT;
      end else if (req_kind_a && req_kind_b) begin
         s1_mode_in = MODE_CIRC_CIRC;
      end else if (req_kind_a) begin
         // circle a against rectangle b
         s1_mode_in = MODE_CIRC_RECT;
         s1_px_in   = {1'b0, req_b_extent_x};
         s1_py_in   = {1'b0, req_b_extent_y};
      end else begin
         s1_mode_in = MODE_CIRC_RECT;
         s1_px_in   = {1'b0, req_a_extent_x};
         s1_py_in   = {1'b0, req_a_extent_y};
         s1_r_in    = req_b_extent_x;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_mode_ff <= s1_mode_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_px_ff   <= s1_px_in;
         s1_py_ff   <= s1_py_in;
         s1_r_ff    <= s1_r_in;
      end
   end

   // ---------------- stage 2: clamp, bound checks before squaring
   logic [W-1:0] dx2, dy2, lim_x, lim_y, ox, oy, big;

   mode_type     s2_mode_ff;
   logic         s2_pre_in, s2_pre_ff;
   logic [W-1:0] s2_ux_in, s2_ux_ff, s2_uy_in, s2_uy_ff, s2_t_in, s2_t_ff;

   assign dx2   = {s1_dx_ff, 1'b0};
   assign dy2   = {s1_dy_ff, 1'b0};
   assign lim_x = {1'b0, s1_px_ff};
   assign lim_y = {1'b0, s1_py_ff};
   assign ox    = (dx2 > lim_x) ? (dx2 - lim_x) : '0;
   assign oy    = (dy2 > lim_y) ? (dy2 - lim_y) : '0;
   assign big   = {1'b0, s1_r_ff, 1'b0};

   always_comb begin
      s2_ux_in  = '0;
      s2_uy_in  = '0;
      s2_t_in   = '0;
      s2_pre_in = 1'b0;
      case (s1_mode_ff)
         MODE_RECT_RECT: begin
            s2_pre_in = (dx2 <= lim_x) && (dy2 <= lim_y);
         end
         MODE_CIRC_CIRC: begin
            s2_ux_in  = {1'b0, s1_dx_ff};
            s2_uy_in  = {1'b0, s1_dy_ff};
            s2_t_in   = lim_x;
            s2_pre_in = (s2_ux_in <= lim_x) && (s2_uy_in <= lim_x);
         end
         MODE_CIRC_RECT: begin
            s2_ux_in  = ox;
            s2_uy_in  = oy;
            s2_t_in   = big;
            s2_pre_in = (ox < big) && (oy < big);
         end
         default: begin
            s2_pre_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_mode_ff <= s1_mode_ff;
         s2_pre_ff  <= s2_pre_in;
         s2_ux_ff   <= s2_ux_in;
         s2_uy_ff   <= s2_uy_in;
         s2_t_ff    <= s2_t_in;
      end
   end

   // ---------------- stage 3: squares
   mode_type     s3_mode_ff;
   logic         s3_pre_ff;
   logic [Q-1:0] s3_ux_sq, s3_uy_sq, s3_t_sq;

   spot_square #(.WIDTH(W)) u_square_x (
      .clock   (clock),
      .enable  (adv3),
      .operand (s2_ux_ff),
      .square  (s3_ux_sq)
   );

   spot_square #(.WIDTH(W)) u_square_y (
      .clock   (clock),
      .enable  (adv3),
      .operand (s2_uy_ff),
      .square  (s3_uy_sq)
   );

   spot_square #(.WIDTH(W)) u_square_t (
      .clock   (clock),
      .enable  (adv3),
      .operand (s2_t_ff),
      .square  (s3_t_sq)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_mode_ff <= s2_mode_ff;
         s3_pre_ff  <= s2_pre_ff;
      end
   end

   // ---------------- stage 4: sum of squares against bound, output word
   logic [Q:0] dist_sq;
   logic [Q:0] bound_sq;
   logic       hit_in, hit_ff;

   assign dist_sq  = {1'b0, s3_ux_sq} + {1'b0, s3_uy_sq};
   assign bound_sq = {1'b0, s3_t_sq};

   always_comb begin
      case (s3_mode_ff)
         MODE_RECT_RECT: hit_in = s3_pre_ff;
         MODE_CIRC_CIRC: hit_in = s3_pre_ff && (dist_sq <= bound_sq);
         MODE_CIRC_RECT: hit_in = s3_pre_ff && (dist_sq < bound_sq);
         default:        hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_hit   = hit_ff;

`ifndef NO_ASSERTIONS
   // input side only backs up when every stage is full and the output stalls
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready))
      else $error("req_ready low with room in the pipeline");

   // pipeline comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !v1_ff && !v2_ff && !v3_ff))
      else $error("stage valid set after reset");

   // a held stage keeps its word
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv3) |=> (v2_ff && $stable(s2_ux_ff) && $stable(s2_pre_ff)))
      else $error("stalled stage two word changed");

   // per-axis clamp check before squaring implies each square is below bound
   a_circ_rect_bound: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && s3_pre_ff && s3_mode_ff == MODE_CIRC_RECT)
         |-> (s3_ux_sq < s3_t_sq && s3_uy_sq < s3_t_sq))
      else $error("circle-rectangle square exceeds radius bound");
`endif

endmodule

`default_nettype wire
